// ===== src/skt_pkg.sv =====
// Shared types and constants of the sorted key table engine.
package skt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int QTY_W       = 32;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_UPDATE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXISTS    = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_PROBE,
      S_COMPARE,
      S_DECIDE,
      S_SHIFT_CHK,
      S_SHIFT_WR,
      S_INSERT,
      S_UPDATE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_mid;
      logic       cmp;
      logic       init_shift;
      logic       rd_shift;
      logic       wr_shift;
      logic       wr_insert;
      logic       wr_update;
      logic       set_status;
      status_type status_val;
      logic       load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic             search_done;
      logic             found;
      logic             full;
      logic             shift_done;
      logic             rsp_free;
      logic [CMD_W-1:0] cmd_code;
   } dp_flags_type;

endpackage

// ===== src/skt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/skt_ctrl.sv =====
// Controller state machine: binary search, shift and write sequencing.
module skt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  skt_pkg::dp_flags_type flags,
   output skt_pkg::ctrl_cmd_type cmd
);

   skt_pkg::state_type state_ff, state_in;
   logic               bad_code;

   assign bad_code = (flags.cmd_code != skt_pkg::CMD_INSERT) &&
                     (flags.cmd_code != skt_pkg::CMD_SEARCH) &&
                     (flags.cmd_code != skt_pkg::CMD_UPDATE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skt_pkg::S_IDLE: begin
            if (req_valid) state_in = skt_pkg::S_DISPATCH;
         end
         skt_pkg::S_DISPATCH: begin
            if ((flags.cmd_code == skt_pkg::CMD_INSERT && flags.full) || bad_code) begin
               state_in = skt_pkg::S_RESP;
            end else begin
               state_in = skt_pkg::S_PROBE;
            end
         end
         skt_pkg::S_PROBE: begin
            state_in = flags.search_done ? skt_pkg::S_DECIDE : skt_pkg::S_COMPARE;
         end
         skt_pkg::S_COMPARE: state_in = skt_pkg::S_PROBE;
         skt_pkg::S_DECIDE: begin
            unique case (flags.cmd_code)
               skt_pkg::CMD_INSERT: begin
                  state_in = flags.found ? skt_pkg::S_RESP : skt_pkg::S_SHIFT_CHK;
               end
               skt_pkg::CMD_UPDATE: begin
                  state_in = flags.found ? skt_pkg::S_UPDATE : skt_pkg::S_RESP;
               end
               default: state_in = skt_pkg::S_RESP;
            endcase
         end
         skt_pkg::S_SHIFT_CHK: begin
            state_in = flags.shift_done ? skt_pkg::S_INSERT : skt_pkg::S_SHIFT_WR;
         end
         skt_pkg::S_SHIFT_WR: state_in = skt_pkg::S_SHIFT_CHK;
         skt_pkg::S_INSERT:   state_in = skt_pkg::S_RESP;
         skt_pkg::S_UPDATE:   state_in = skt_pkg::S_RESP;
         skt_pkg::S_RESP: begin
            if (flags.rsp_free) state_in = skt_pkg::S_IDLE;
         end
         default: state_in = skt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.status_val = skt_pkg::ST_NOT_FOUND;
      req_stall      = (state_ff != skt_pkg::S_IDLE);
      unique case (state_ff)
         skt_pkg::S_IDLE: cmd.load_req = req_valid;
         skt_pkg::S_DISPATCH: begin
            if (flags.cmd_code == skt_pkg::CMD_INSERT && flags.full) begin
               cmd.set_status = 1'b1;
               cmd.status_val = skt_pkg::ST_FULL;
            end else if (bad_code) begin
               cmd.set_status = 1'b1;
               cmd.status_val = skt_pkg::ST_NOT_FOUND;
            end
         end
         skt_pkg::S_PROBE:   cmd.rd_mid = !flags.search_done;
         skt_pkg::S_COMPARE: cmd.cmp = 1'b1;
         skt_pkg::S_DECIDE: begin
            unique case (flags.cmd_code)
               skt_pkg::CMD_INSERT: begin
                  if (flags.found) begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = skt_pkg::ST_EXISTS;
                  end else begin
                     cmd.init_shift = 1'b1;
                  end
               end
               skt_pkg::CMD_SEARCH: begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = flags.found ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
               end
               skt_pkg::CMD_UPDATE: begin
                  if (!flags.found) begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = skt_pkg::ST_NOT_FOUND;
                  end
               end
               default: begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = skt_pkg::ST_NOT_FOUND;
               end
            endcase
         end
         skt_pkg::S_SHIFT_CHK: cmd.rd_shift = !flags.shift_done;
         skt_pkg::S_SHIFT_WR:  cmd.wr_shift = 1'b1;
         skt_pkg::S_INSERT: begin
            cmd.wr_insert  = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status_val = skt_pkg::ST_OK;
         end
         skt_pkg::S_UPDATE: begin
            cmd.wr_update  = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status_val = skt_pkg::ST_OK;
         end
         skt_pkg::S_RESP: cmd.load_rsp = flags.rsp_free;
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::S_SHIFT_WR) |-> ($past(state_ff) == skt_pkg::S_SHIFT_CHK))
      else $error("shift write without a preceding shift read");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_req) |=> (state_ff == skt_pkg::S_DISPATCH))
      else $error("accepted item did not start dispatch");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::S_RESP && flags.rsp_free) |=> (state_ff == skt_pkg::S_IDLE))
      else $error("result handed off but controller not idle");

endmodule

// ===== src/skt_datapath.sv =====
// Datapath: request registers, search bounds, table RAMs, entry count, result register.
module skt_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [skt_pkg::CMD_W-1:0]           req_command,
   input  logic signed [skt_pkg::KEY_W-1:0]    req_part_key,
   input  logic signed [skt_pkg::QTY_W-1:0]    req_amount,
   input  skt_pkg::ctrl_cmd_type               cmd,
   output skt_pkg::dp_flags_type               flags,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [skt_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [skt_pkg::QTY_W-1:0]    rsp_quantity_out
);

   localparam int CNT_W = skt_pkg::CNT_W;
   localparam int IDX_W = skt_pkg::IDX_W;

   logic [skt_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [skt_pkg::KEY_W-1:0] key_ff, key_in;
   logic signed [skt_pkg::QTY_W-1:0] amt_ff, amt_in;
   logic signed [skt_pkg::QTY_W-1:0] qty_ff, qty_in;
   logic [CNT_W-1:0]                 lo_ff, lo_in;
   logic [CNT_W-1:0]                 hi_ff, hi_in;
   logic [CNT_W-1:0]                 sh_ff, sh_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             found_ff, found_in;
   skt_pkg::status_type              status_ff, status_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   skt_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic signed [skt_pkg::QTY_W-1:0] rsp_qty_ff, rsp_qty_in;

   logic [CNT_W:0]                   bound_sum;
   logic [CNT_W-1:0]                 mid;
   logic [CNT_W-1:0]                 sh_prev;
   logic signed [skt_pkg::KEY_W-1:0] key_rd;
   logic signed [skt_pkg::QTY_W-1:0] qty_rd;
   logic signed [skt_pkg::QTY_W-1:0] qty_sum;
   logic                             rd_en;
   logic [IDX_W-1:0]                 rd_addr;
   logic                             key_wr_en;
   logic                             qty_wr_en;
   logic [IDX_W-1:0]                 wr_addr;
   logic [skt_pkg::KEY_W-1:0]        key_wr_data;
   logic [skt_pkg::QTY_W-1:0]        qty_wr_data;

   assign bound_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = bound_sum[CNT_W:1];
   assign sh_prev   = sh_ff - CNT_W'(1);
   assign qty_sum   = qty_ff + amt_ff;

   assign rd_en   = cmd.rd_mid | cmd.rd_shift;
   assign rd_addr = cmd.rd_shift ? sh_prev[IDX_W-1:0] : mid[IDX_W-1:0];

   always_comb begin
      key_wr_en   = 1'b0;
      qty_wr_en   = 1'b0;
      wr_addr     = lo_ff[IDX_W-1:0];
      key_wr_data = key_ff;
      qty_wr_data = amt_ff;
      if (cmd.wr_shift) begin
         key_wr_en   = 1'b1;
         qty_wr_en   = 1'b1;
         wr_addr     = sh_ff[IDX_W-1:0];
         key_wr_data = key_rd;
         qty_wr_data = qty_rd;
      end else if (cmd.wr_insert) begin
         key_wr_en = 1'b1;
         qty_wr_en = 1'b1;
      end else if (cmd.wr_update) begin
         qty_wr_en   = 1'b1;
         qty_wr_data = qty_sum;
      end
   end

   skt_ram #(
      .WIDTH (skt_pkg::KEY_W),
      .DEPTH (skt_pkg::TABLE_DEPTH)
   ) key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   skt_ram #(
      .WIDTH (skt_pkg::QTY_W),
      .DEPTH (skt_pkg::TABLE_DEPTH)
   ) qty_ram (
      .clock   (clock),
      .wr_en   (qty_wr_en),
      .wr_addr (wr_addr),
      .wr_data (qty_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (qty_rd)
   );

   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      amt_in        = amt_ff;
      qty_in        = qty_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      sh_in         = sh_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_qty_in    = rsp_qty_ff;

      if (cmd.load_req) begin
         cmd_in   = req_command;
         key_in   = req_part_key;
         amt_in   = req_amount;
         lo_in    = '0;
         hi_in    = count_ff;
         found_in = 1'b0;
      end
      if (cmd.cmp) begin
         if (key_rd < key_ff) begin
            lo_in = mid + CNT_W'(1);
         end else begin
            hi_in = mid;
         end
         if (key_rd == key_ff) begin
            found_in = 1'b1;
            qty_in   = qty_rd;
         end
      end
      if (cmd.init_shift) sh_in = count_ff;
      if (cmd.wr_shift)   sh_in = sh_prev;
      if (cmd.wr_insert) begin
         count_in = count_ff + CNT_W'(1);
         qty_in   = amt_ff;
      end
      if (cmd.wr_update)  qty_in = qty_sum;
      if (cmd.set_status) status_in = cmd.status_val;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_qty_in    = (status_ff == skt_pkg::ST_OK) ? qty_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      amt_ff        <= amt_in;
      qty_ff        <= qty_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      sh_ff         <= sh_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_qty_ff    <= rsp_qty_in;
   end

   assign flags.search_done = (lo_ff >= hi_ff);
   assign flags.found       = found_ff;
   assign flags.full        = (count_ff >= CNT_W'(skt_pkg::TABLE_DEPTH));
   assign flags.shift_done  = (sh_ff == lo_ff);
   assign flags.rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign flags.cmd_code    = cmd_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_quantity_out = rsp_qty_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(skt_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_insert |-> (count_ff < CNT_W'(skt_pkg::TABLE_DEPTH)))
      else $error("insert write into a full table");

   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("entry count did not advance on insert");

   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_shift |-> (sh_ff > lo_ff))
      else $error("shift below the insert position");

endmodule

// ===== src/sorted_key_table_engine_core.sv =====
// Top level of the sorted key table engine: controller plus datapath.
//
//  channel | dir | handshake            | fields
//  req     | in  | req_valid/req_stall  | req_command, req_part_key, req_amount
//  rsp     | out | rsp_valid/rsp_stall  | rsp_status, rsp_quantity_out
//
// Search is a binary search over the n stored entries, a probe and a compare per step, through
// the key RAM's single registered read port; update adds a write of the summed quantity.
// Insert moves the entries above position p up by one, a read and a write per entry.
// Full-table insert or unused command code goes straight to the result. The controller returns
// to idle after each result load. Reset clears the entry count and the result valid flag; the
// RAMs are not cleared. A waiting result holds in its register while the next item is accepted.
module sorted_key_table_engine_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [skt_pkg::CMD_W-1:0]        req_command,
   input  logic signed [skt_pkg::KEY_W-1:0] req_part_key,
   input  logic signed [skt_pkg::QTY_W-1:0] req_amount,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [skt_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [skt_pkg::QTY_W-1:0] rsp_quantity_out
);

   skt_pkg::ctrl_cmd_type ctrl_cmd;
   skt_pkg::dp_flags_type dp_flags;

   skt_ctrl ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flags     (dp_flags),
      .cmd       (ctrl_cmd)
   );

   skt_datapath datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_part_key     (req_part_key),
      .req_amount       (req_amount),
      .cmd              (ctrl_cmd),
      .flags            (dp_flags),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_quantity_out (rsp_quantity_out)
   );

endmodule

// ===== tb/sorted_key_table_engine_core_tb.sv =====
// Self-checking testbench of the sorted key table engine: directed table, then random traffic.
module sorted_key_table_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [skt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_MAX   = 12;
   localparam int HOLD_LEN   = 300;
   localparam int DRAIN_LEN  = 200;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic [skt_pkg::CMD_W-1:0] cmd;
      logic [skt_pkg::KEY_W-1:0] key;
      logic [skt_pkg::QTY_W-1:0] amt;
      bit                        typed;
      skt_pkg::status_type       st;
      logic [skt_pkg::QTY_W-1:0] qty;
   } stim_row_type;

   typedef struct {
      skt_pkg::status_type       st;
      logic [skt_pkg::QTY_W-1:0] qty;
   } table_result_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [skt_pkg::CMD_W-1:0]        req_command;
   logic signed [skt_pkg::KEY_W-1:0] req_part_key;
   logic signed [skt_pkg::QTY_W-1:0] req_amount;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [skt_pkg::STATUS_W-1:0]     rsp_status;
   logic signed [skt_pkg::QTY_W-1:0] rsp_quantity_out;

   logic [skt_pkg::KEY_W-1:0] tbl_key [$];
   logic [skt_pkg::QTY_W-1:0] tbl_qty [$];
   int                        tbl_count;

   table_result_type pending_rsp [$];
   stim_row_type     dir_tab [$];
   int               error_count = 0;
   int               quiet_cycles = 0;
   bit               idle_on;
   int               hold_req;

   sorted_key_table_engine_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_part_key     (req_part_key),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_quantity_out (rsp_quantity_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void table_apply(input logic [skt_pkg::CMD_W-1:0] cmd,
                                       input logic [skt_pkg::KEY_W-1:0] key,
                                       input logic [skt_pkg::QTY_W-1:0] amt,
                                       output skt_pkg::status_type st,
                                       output logic [skt_pkg::QTY_W-1:0] qty);
      int pos;
      bit hit;
      pos = 0;
      while (pos < tbl_count && $signed(tbl_key[pos]) < $signed(key)) pos++;
      hit = (pos < tbl_count) && (tbl_key[pos] == key);
      st  = skt_pkg::ST_NOT_FOUND;
      qty = '0;
      case (cmd)
         skt_pkg::CMD_INSERT: begin
            if (tbl_count >= skt_pkg::TABLE_DEPTH) begin
               st = skt_pkg::ST_FULL;
            end else if (hit) begin
               st = skt_pkg::ST_EXISTS;
            end else begin
               tbl_key.insert(pos, key);
               tbl_qty.insert(pos, amt);
               tbl_count++;
               st  = skt_pkg::ST_OK;
               qty = amt;
            end
         end
         skt_pkg::CMD_SEARCH: begin
            if (hit) begin
               st  = skt_pkg::ST_OK;
               qty = tbl_qty[pos];
            end
         end
         skt_pkg::CMD_UPDATE: begin
            if (hit) begin
               tbl_qty[pos] = tbl_qty[pos] + amt;
               st  = skt_pkg::ST_OK;
               qty = tbl_qty[pos];
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (tbl_count > 0 && r < 55) return tbl_key[$urandom_range(0, tbl_count - 1)];
      if (r < 75) return $urandom_range(0, 40) - 20;
      return $urandom;
   endfunction

   task automatic offer(input logic [skt_pkg::CMD_W-1:0] cmd,
                        input logic [skt_pkg::KEY_W-1:0] key,
                        input logic [skt_pkg::QTY_W-1:0] amt, input bit typed,
                        input skt_pkg::status_type st,
                        input logic [skt_pkg::QTY_W-1:0] qty);
      int                        gap;
      skt_pkg::status_type       p_st;
      logic [skt_pkg::QTY_W-1:0] p_qty;
      table_result_type          e;
      gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_part_key <= key;
      req_amount   <= amt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      table_apply(cmd, key, amt, p_st, p_qty);
      e.st  = typed ? st : p_st;
      e.qty = typed ? qty : p_qty;
      pending_rsp.push_back(e);
   endtask

   task automatic random_item(input int insert_pct);
      int                        r;
      logic [skt_pkg::CMD_W-1:0] cmd;
      logic [skt_pkg::QTY_W-1:0] amt;
      r = $urandom_range(0, 99);
      if (r < 5) cmd = CMD_UNUSED;
      else if (r < 5 + insert_pct) cmd = skt_pkg::CMD_INSERT;
      else if (r < 5 + insert_pct + (95 - insert_pct) / 2) cmd = skt_pkg::CMD_SEARCH;
      else cmd = skt_pkg::CMD_UPDATE;
      amt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) - 10 : $urandom;
      offer(cmd, pick_key(), amt, 1'b0, skt_pkg::ST_OK, '0);
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      int n;
      int hold_seen;
      hold_seen = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            n = HOLD_LEN;
         end else begin
            n = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_rsp
      table_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected item status %0d quantity %h",
                     $time, rsp_status, rsp_quantity_out);
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.st) begin
               $display("%0t: status expected %0d actual %0d", $time, e.st, rsp_status);
               error_count++;
            end
            if (rsp_quantity_out !== e.qty) begin
               $display("%0t: quantity expected %h actual %h",
                        $time, e.qty, rsp_quantity_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [skt_pkg::KEY_W-1:0] k;
      tbl_count    = 0;
      idle_on      = 1'b1;
      hold_req     = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_command  <= skt_pkg::CMD_INSERT;
      req_part_key <= '0;
      req_amount   <= '0;

      dir_tab.push_back('{skt_pkg::CMD_SEARCH, 32'h00000000, 32'h00000000, 1,
                          skt_pkg::ST_NOT_FOUND, 32'h0});
      dir_tab.push_back('{skt_pkg::CMD_UPDATE, 32'hffffffff, 32'h00000005, 1,
                          skt_pkg::ST_NOT_FOUND, 32'h0});
      dir_tab.push_back('{CMD_UNUSED, 32'h00000000, 32'hffffffff, 1,
                          skt_pkg::ST_NOT_FOUND, 32'h0});
      dir_tab.push_back('{skt_pkg::CMD_INSERT, 32'h80000000, 32'h7fffffff, 1,
                          skt_pkg::ST_OK, 32'h7fffffff});
      dir_tab.push_back('{skt_pkg::CMD_INSERT, 32'h7fffffff, 32'h80000000, 1,
                          skt_pkg::ST_OK, 32'h80000000});
      dir_tab.push_back('{skt_pkg::CMD_INSERT, 32'h00000000, 32'h00000000, 1,
                          skt_pkg::ST_OK, 32'h00000000});
      dir_tab.push_back('{skt_pkg::CMD_INSERT, 32'hffffffff, 32'hffffffff, 1,
                          skt_pkg::ST_OK, 32'hffffffff});
      dir_tab.push_back('{skt_pkg::CMD_INSERT, 32'h00000000, 32'h00012345, 1,
                          skt_pkg::ST_EXISTS, 32'h0});
      dir_tab.push_back('{skt_pkg::CMD_INSERT, 32'h80000000, 32'h00000001, 1,
                          skt_pkg::ST_EXISTS, 32'h0});
      dir_tab.push_back('{skt_pkg::CMD_SEARCH, 32'h7fffffff, 32'h00000000, 1,
                          skt_pkg::ST_OK, 32'h80000000});
      dir_tab.push_back('{skt_pkg::CMD_SEARCH, 32'h80000000, 32'haaaaaaaa, 1,
                          skt_pkg::ST_OK, 32'h7fffffff});
      dir_tab.push_back('{skt_pkg::CMD_UPDATE, 32'h80000000, 32'h00000001, 1,
                          skt_pkg::ST_OK, 32'h80000000});
      dir_tab.push_back('{skt_pkg::CMD_UPDATE, 32'h7fffffff, 32'hffffffff, 1,
                          skt_pkg::ST_OK, 32'h7fffffff});
      dir_tab.push_back('{skt_pkg::CMD_UPDATE, 32'hffffffff, 32'h80000000, 1,
                          skt_pkg::ST_OK, 32'h7fffffff});
      dir_tab.push_back('{skt_pkg::CMD_SEARCH, 32'h00000001, 32'h00000000, 1,
                          skt_pkg::ST_NOT_FOUND, 32'h0});
      dir_tab.push_back('{CMD_UNUSED, 32'h00000000, 32'h00000001, 1,
                          skt_pkg::ST_NOT_FOUND, 32'h0});
      dir_tab.push_back('{skt_pkg::CMD_INSERT, 32'h00000001, 32'h55555555, 0,
                          skt_pkg::ST_OK, 32'h0});
      dir_tab.push_back('{skt_pkg::CMD_INSERT, 32'hfffffffe, 32'haaaaaaaa, 0,
                          skt_pkg::ST_OK, 32'h0});
      dir_tab.push_back('{skt_pkg::CMD_SEARCH, 32'h00000000, 32'h00000000, 0,
                          skt_pkg::ST_OK, 32'h0});
      dir_tab.push_back('{skt_pkg::CMD_UPDATE, 32'h00000001, 32'h7fffffff, 0,
                          skt_pkg::ST_OK, 32'h0});
      dir_tab.push_back('{skt_pkg::CMD_SEARCH, 32'hfffffffe, 32'h00000000, 0,
                          skt_pkg::ST_OK, 32'h0});
      dir_tab.push_back('{skt_pkg::CMD_UPDATE, 32'h00000000, 32'h80000000, 0,
                          skt_pkg::ST_OK, 32'h0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i])
         offer(dir_tab[i].cmd, dir_tab[i].key, dir_tab[i].amt,
               dir_tab[i].typed, dir_tab[i].st, dir_tab[i].qty);

      for (int i = 0; i < 250; i++) begin
         idle_on = ((i / 50) % 2) == 0;
         random_item(30);
      end

      // pause the sender until every result is back
      req_valid <= 1'b0;
      wait_drained();

      // hold off the receiver while the sender keeps offering
      idle_on  = 1'b0;
      hold_req = hold_req + 1;
      for (int i = 0; i < 40; i++) random_item(30);

      // fill the table, then hit it with inserts while full
      idle_on = 1'b1;
      while (tbl_count < skt_pkg::TABLE_DEPTH)
         offer(skt_pkg::CMD_INSERT, $urandom, $urandom, 1'b0, skt_pkg::ST_OK, '0);
      for (int i = 0; i < 20; i++) begin
         k = (i % 2 == 0) ? tbl_key[$urandom_range(0, skt_pkg::TABLE_DEPTH - 1)] : $urandom;
         offer(skt_pkg::CMD_INSERT, k, $urandom, 1'b0, skt_pkg::ST_OK, '0);
      end

      for (int i = 0; i < 400; i++) begin
         idle_on = ((i / 60) % 3) != 1;
         random_item(20);
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_LEN) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/skt_pkg.sv
src/skt_ram.sv
src/skt_ctrl.sv
src/skt_datapath.sv
src/sorted_key_table_engine_core.sv
tb/sorted_key_table_engine_core_tb.sv
